// ===== hdl/pdrs_pkg.sv =====
package pdrs_pkg;

  // Event codes carried in the mode field
  localparam logic [2:0] MODE_TICK   = 3'd0;
  localparam logic [2:0] MODE_READ   = 3'd1;
  localparam logic [2:0] MODE_DONE   = 3'd2;
  localparam logic [2:0] MODE_ERROR  = 3'd3;
  localparam logic [2:0] MODE_ENABLE = 3'd4;
  localparam logic [2:0] MODE_CLEAR  = 3'd5;
  localparam logic [2:0] MODE_RESET  = 3'd6;

  // Controller state codes as reported on controller_state
  localparam logic [1:0] CTRL_IDLE  = 2'd0;
  localparam logic [1:0] CTRL_WAIT  = 2'd1;
  localparam logic [1:0] CTRL_RETRY = 2'd2;
  localparam logic [1:0] CTRL_ERROR = 2'd3;

  // Read attempt result codes
  localparam logic [1:0] RES_OK   = 2'd0;
  localparam logic [1:0] RES_ERR  = 2'd1;
  localparam logic [1:0] RES_BUSY = 2'd2;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_DEVICE_COUNT = 3'd0;
  localparam logic [2:0] REG_AUTO_RETRY   = 3'd1;
  localparam logic [2:0] REG_SEQ_MODE     = 3'd2;
  localparam logic [2:0] REG_POLL_INTVL   = 3'd3;
  localparam logic [2:0] REG_DEV_ADDR0    = 3'd4;
  localparam logic [2:0] REG_DEV_ADDR1    = 3'd5;
  localparam logic [2:0] REG_DEV_ADDR2    = 3'd6;
  localparam logic [2:0] REG_DEV_ADDR3    = 3'd7;

  localparam logic [2:0]  NONE_ID          = 3'd4;
  localparam logic [2:0]  MAX_DEVICES      = 3'd4;
  localparam logic [15:0] TIMEOUT_TICKS    = 16'd100;
  localparam logic [15:0] MAX_RETRIES      = 16'd3;
  localparam logic [15:0] RETRY_DELAY      = 16'd10;
  localparam logic [15:0] ERROR_HOLD       = 16'd50;
  localparam logic [15:0] DEFAULT_INTERVAL = 16'd20;
  localparam logic [15:0] SAT_WIDE         = 16'hFFFF;
  localparam logic [15:0] SAT_NARROW       = 16'h000F;

  typedef struct packed {
    logic [2:0] mode;
    logic [1:0] slave_id;
    logic       enable_value;
    logic       bus_ready;
    logic       start_ok;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        start_read;
    logic [9:0]  target_address;
    logic        abort_transfer;
    logic [1:0]  controller_state;
    logic [2:0]  active_device;
    logic        data_ready;
    logic [15:0] error_count;
    logic [15:0] success_count;
  } out_t;

  typedef struct packed {
    logic [2:0]       device_count;
    logic             auto_retry;
    logic             sequential_mode;
    logic [15:0]      poll_interval;
    logic [3:0][9:0]  dev_addr;
  } cfg_t;

  // Request to and response from the shared arithmetic unit
  typedef struct packed {
    logic [15:0] a;
    logic [15:0] b;
    logic        narrow;
  } alu_req_t;

  typedef struct packed {
    logic [15:0] inc;
    logic        ge;
    logic        gt;
  } alu_rsp_t;

  // Per-device statistics entry
  typedef struct packed {
    logic [15:0] err;
    logic [15:0] succ;
    logic [3:0]  retry;
  } cnt_entry_t;

  // Pending counter operations, worked off one per cycle
  typedef struct packed {
    logic clr_all;
    logic inc_err;
    logic inc_retry;
    logic chk_retry;
    logic inc_succ;
    logic clr_retry;
  } cop_t;

  // v modulo n for v in 1..4 and n in 1..4
  function automatic logic [1:0] mod_small(input logic [2:0] v, input logic [2:0] n);
    logic [2:0] r;
    begin
      r = 3'd0;
      case (n)
        3'd2: r = {2'b00, v[0]};
        3'd3: r = (v >= 3'd3) ? v - 3'd3 : v;
        3'd4: r = (v >= 3'd4) ? v - 3'd4 : v;
        default: r = 3'd0;
      endcase
      return r[1:0];
    end
  endfunction

endpackage

// ===== hdl/polled_device_read_scheduler_core.sv =====
// Polled device read scheduler: one event per start, one result strobe per event.
// A tick adds two timer steps, a poll walks one device entry per cycle, and each counter
// update goes through the shared increment/compare unit. busy drops after the strobe.
// A new event is taken only once busy has dropped; the receiver cannot stall.
// Reset (rst_n low, synchronous): controller idle, no active device, counters cleared.
module polled_device_read_scheduler_core (
  input  logic                 clk,
  input  logic                 rst_n,
  // event channel
  input  logic                 start,
  output logic                 busy,
  input  pdrs_pkg::in_t        in_data,
  // result channel
  output logic                 out_valid,
  output pdrs_pkg::out_t       out_data,
  // configuration port
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [4:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  // Sequencer steps: timer advances, event evaluation, poll walk, read attempt,
  // counter updates through the shared unit, then the result beat.
  typedef enum logic [7:0] {
    SQ_IDLE = 8'b00000001,
    SQ_STIM = 8'b00000010,
    SQ_PTIM = 8'b00000100,
    SQ_EVAL = 8'b00001000,
    SQ_POLL = 8'b00010000,
    SQ_TRY  = 8'b00100000,
    SQ_CNT  = 8'b01000000,
    SQ_OUT  = 8'b10000000
  } seq_t;

  pdrs_pkg::cfg_t      cfg;
  logic                seq_wr;
  pdrs_pkg::alu_req_t  alu_req;
  pdrs_pkg::alu_rsp_t  alu_rsp;

  seq_t                state_r, state_nxt;
  pdrs_pkg::in_t       item_r, item_nxt;
  logic [1:0]          ctrl_r, ctrl_nxt;
  logic [2:0]          active_r, active_nxt;
  logic [15:0]         stimer_r, stimer_nxt;
  logic [15:0]         ptimer_r, ptimer_nxt;
  logic [1:0]          next_idx_r, next_idx_nxt;
  logic [3:0]          en_r, en_nxt;
  logic [3:0]          rdy_r, rdy_nxt;
  pdrs_pkg::cnt_entry_t cnt_r [4];
  logic [1:0]          status_r, status_nxt;
  logic                start_rd_r, start_rd_nxt;
  logic [9:0]          addr_r, addr_nxt;
  logic                abort_r, abort_nxt;
  pdrs_pkg::cop_t      cop_r, cop_nxt;
  logic [1:0]          cnt_id_r, cnt_id_nxt;
  logic [1:0]          try_id_r, try_id_nxt;
  logic                poll_r, poll_nxt;
  logic [1:0]          walk_r, walk_nxt;

  logic                cnt_wr;
  pdrs_pkg::cnt_entry_t cnt_wdata;
  pdrs_pkg::cnt_entry_t rd_ent;
  logic [1:0]          rd_id;
  logic [2:0]          dev_n;
  logic                valid_active;
  logic                sid_ok;

  pdrs_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg),
    .seq_wr  (seq_wr)
  );

  pdrs_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  // Device count above the maximum acts as the maximum
  assign dev_n        = (cfg.device_count > pdrs_pkg::MAX_DEVICES) ? pdrs_pkg::MAX_DEVICES
                                                                   : cfg.device_count;
  assign valid_active = active_r < dev_n;
  assign sid_ok       = {1'b0, item_r.slave_id} < dev_n;

  // Single read address into the statistics: the queried device on the result beat,
  // the device under update otherwise.
  assign rd_id  = (state_r == SQ_OUT) ? item_r.slave_id : cnt_id_r;
  assign rd_ent = cnt_r[rd_id];

  always_comb begin
    state_nxt    = state_r;
    item_nxt     = item_r;
    ctrl_nxt     = ctrl_r;
    active_nxt   = active_r;
    stimer_nxt   = stimer_r;
    ptimer_nxt   = ptimer_r;
    next_idx_nxt = next_idx_r;
    en_nxt       = en_r;
    rdy_nxt      = rdy_r;
    status_nxt   = status_r;
    start_rd_nxt = start_rd_r;
    addr_nxt     = addr_r;
    abort_nxt    = abort_r;
    cop_nxt      = cop_r;
    cnt_id_nxt   = cnt_id_r;
    try_id_nxt   = try_id_r;
    poll_nxt     = poll_r;
    walk_nxt     = walk_r;
    cnt_wr       = 1'b0;
    cnt_wdata    = rd_ent;
    alu_req      = '0;

    unique case (state_r)
      SQ_IDLE: begin
        if (start) begin
          item_nxt     = in_data;
          status_nxt   = pdrs_pkg::RES_OK;
          start_rd_nxt = 1'b0;
          addr_nxt     = 10'd0;
          abort_nxt    = 1'b0;
          cop_nxt      = '0;
          poll_nxt     = 1'b0;
          walk_nxt     = 2'd0;
          state_nxt    = (in_data.mode == pdrs_pkg::MODE_TICK) ? SQ_STIM : SQ_EVAL;
        end
      end

      SQ_STIM: begin
        // advance the state timer, saturating
        alu_req.a  = stimer_r;
        stimer_nxt = alu_rsp.inc;
        state_nxt  = SQ_PTIM;
      end

      SQ_PTIM: begin
        alu_req.a  = ptimer_r;
        ptimer_nxt = alu_rsp.inc;
        state_nxt  = SQ_EVAL;
      end

      SQ_EVAL: begin
        state_nxt = SQ_CNT;
        case (item_r.mode)
          pdrs_pkg::MODE_TICK: begin
            case (ctrl_r)
              pdrs_pkg::CTRL_IDLE: begin
                alu_req.a = ptimer_r;
                alu_req.b = cfg.poll_interval;
                if (cfg.sequential_mode && alu_rsp.ge) begin
                  poll_nxt  = 1'b1;
                  state_nxt = SQ_POLL;
                end
              end
              pdrs_pkg::CTRL_WAIT: begin
                // transfer timeout: abort and hold off
                alu_req.a = stimer_r;
                alu_req.b = pdrs_pkg::TIMEOUT_TICKS;
                if (alu_rsp.gt) begin
                  if (valid_active) begin
                    cop_nxt.inc_err   = 1'b1;
                    cop_nxt.inc_retry = 1'b1;
                    cnt_id_nxt        = active_r[1:0];
                    abort_nxt         = 1'b1;
                  end
                  ctrl_nxt   = pdrs_pkg::CTRL_ERROR;
                  stimer_nxt = 16'd0;
                  active_nxt = pdrs_pkg::NONE_ID;
                end
              end
              pdrs_pkg::CTRL_RETRY: begin
                alu_req.a = stimer_r;
                alu_req.b = pdrs_pkg::RETRY_DELAY;
                if (!valid_active) begin
                  ctrl_nxt = pdrs_pkg::CTRL_IDLE;
                end else if (alu_rsp.gt) begin
                  // restart the read without looking at bus_ready
                  start_rd_nxt = 1'b1;
                  addr_nxt     = cfg.dev_addr[active_r[1:0]];
                  stimer_nxt   = 16'd0;
                  if (item_r.start_ok) begin
                    ctrl_nxt = pdrs_pkg::CTRL_WAIT;
                  end else begin
                    ctrl_nxt   = pdrs_pkg::CTRL_ERROR;
                    active_nxt = pdrs_pkg::NONE_ID;
                  end
                end
              end
              default: begin
                // error hold-off
                alu_req.a = stimer_r;
                alu_req.b = pdrs_pkg::ERROR_HOLD;
                if (alu_rsp.gt) begin
                  ctrl_nxt = pdrs_pkg::CTRL_IDLE;
                end
              end
            endcase
          end
          pdrs_pkg::MODE_READ: begin
            try_id_nxt = item_r.slave_id;
            state_nxt  = SQ_TRY;
          end
          pdrs_pkg::MODE_DONE: begin
            if (valid_active && en_r[active_r[1:0]]) begin
              rdy_nxt[active_r[1:0]] = 1'b1;
              cop_nxt.inc_succ       = 1'b1;
              cop_nxt.clr_retry      = 1'b1;
              cnt_id_nxt             = active_r[1:0];
            end
            ctrl_nxt   = pdrs_pkg::CTRL_IDLE;
            active_nxt = pdrs_pkg::NONE_ID;
          end
          pdrs_pkg::MODE_ERROR: begin
            stimer_nxt = 16'd0;
            if (valid_active) begin
              // retry decision waits for the updated retry count
              cop_nxt.inc_err   = 1'b1;
              cop_nxt.inc_retry = 1'b1;
              cop_nxt.chk_retry = 1'b1;
              cnt_id_nxt        = active_r[1:0];
            end else begin
              ctrl_nxt   = pdrs_pkg::CTRL_ERROR;
              active_nxt = pdrs_pkg::NONE_ID;
            end
          end
          pdrs_pkg::MODE_ENABLE: begin
            if (sid_ok) begin
              en_nxt[item_r.slave_id] = item_r.enable_value;
            end
          end
          pdrs_pkg::MODE_CLEAR: begin
            if (sid_ok) begin
              rdy_nxt[item_r.slave_id] = 1'b0;
            end
          end
          pdrs_pkg::MODE_RESET: begin
            if (sid_ok) begin
              cop_nxt.clr_all = 1'b1;
              cnt_id_nxt      = item_r.slave_id;
            end
          end
          default: ;
        endcase
      end

      SQ_POLL: begin
        // walk one device entry per cycle from next_idx
        if (dev_n == 3'd0) begin
          status_nxt = pdrs_pkg::RES_ERR;
          state_nxt  = SQ_CNT;
        end else begin
          next_idx_nxt = pdrs_pkg::mod_small({1'b0, next_idx_r} + 3'd1, dev_n);
          if (en_r[next_idx_r]) begin
            try_id_nxt = next_idx_r;
            state_nxt  = SQ_TRY;
          end else if (({1'b0, walk_r} + 3'd1) == dev_n) begin
            status_nxt = pdrs_pkg::RES_ERR;
            state_nxt  = SQ_CNT;
          end else begin
            walk_nxt = walk_r + 2'd1;
          end
        end
      end

      SQ_TRY: begin
        state_nxt = SQ_CNT;
        if (({1'b0, try_id_r} >= dev_n) || !en_r[try_id_r]) begin
          status_nxt = pdrs_pkg::RES_ERR;
        end else if ((ctrl_r != pdrs_pkg::CTRL_IDLE) || !item_r.bus_ready) begin
          status_nxt = pdrs_pkg::RES_BUSY;
        end else begin
          active_nxt   = {1'b0, try_id_r};
          start_rd_nxt = 1'b1;
          addr_nxt     = cfg.dev_addr[try_id_r];
          stimer_nxt   = 16'd0;
          if (item_r.start_ok) begin
            ctrl_nxt   = pdrs_pkg::CTRL_WAIT;
            status_nxt = pdrs_pkg::RES_OK;
            if (poll_r) begin
              ptimer_nxt = 16'd0;
            end
          end else begin
            ctrl_nxt        = pdrs_pkg::CTRL_ERROR;
            status_nxt      = pdrs_pkg::RES_ERR;
            cop_nxt.inc_err = 1'b1;
            cnt_id_nxt      = try_id_r;
          end
        end
      end

      SQ_CNT: begin
        // one statistics operation per cycle through the shared unit
        if (cop_r.clr_all) begin
          cnt_wr          = 1'b1;
          cnt_wdata       = '0;
          cop_nxt.clr_all = 1'b0;
        end else if (cop_r.inc_err) begin
          alu_req.a       = rd_ent.err;
          cnt_wr          = 1'b1;
          cnt_wdata.err   = alu_rsp.inc;
          cop_nxt.inc_err = 1'b0;
        end else if (cop_r.inc_retry) begin
          alu_req.a         = {12'd0, rd_ent.retry};
          alu_req.narrow    = 1'b1;
          cnt_wr            = 1'b1;
          cnt_wdata.retry   = alu_rsp.inc[3:0];
          cop_nxt.inc_retry = 1'b0;
        end else if (cop_r.chk_retry) begin
          alu_req.a         = {12'd0, rd_ent.retry};
          alu_req.b         = pdrs_pkg::MAX_RETRIES;
          cop_nxt.chk_retry = 1'b0;
          if (cfg.auto_retry && !alu_rsp.ge) begin
            ctrl_nxt = pdrs_pkg::CTRL_RETRY;
          end else begin
            ctrl_nxt        = pdrs_pkg::CTRL_ERROR;
            active_nxt      = pdrs_pkg::NONE_ID;
            cnt_wr          = 1'b1;
            cnt_wdata.retry = 4'd0;
          end
        end else if (cop_r.inc_succ) begin
          alu_req.a        = rd_ent.succ;
          cnt_wr           = 1'b1;
          cnt_wdata.succ   = alu_rsp.inc;
          cop_nxt.inc_succ = 1'b0;
        end else if (cop_r.clr_retry) begin
          cnt_wr            = 1'b1;
          cnt_wdata.retry   = 4'd0;
          cop_nxt.clr_retry = 1'b0;
        end else begin
          state_nxt = SQ_OUT;
        end
      end

      SQ_OUT: begin
        state_nxt = SQ_IDLE;
      end

      default: begin
        state_nxt = SQ_IDLE;
      end
    endcase

    // writing the sequential mode register restarts polling
    if (seq_wr) begin
      ptimer_nxt   = 16'd0;
      next_idx_nxt = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= SQ_IDLE;
      ctrl_r     <= pdrs_pkg::CTRL_IDLE;
      active_r   <= pdrs_pkg::NONE_ID;
      stimer_r   <= 16'd0;
      ptimer_r   <= 16'd0;
      next_idx_r <= 2'd0;
      en_r       <= 4'b1111;
      rdy_r      <= 4'b0000;
      cop_r      <= '0;
      poll_r     <= 1'b0;
      walk_r     <= 2'd0;
    end else begin
      state_r    <= state_nxt;
      ctrl_r     <= ctrl_nxt;
      active_r   <= active_nxt;
      stimer_r   <= stimer_nxt;
      ptimer_r   <= ptimer_nxt;
      next_idx_r <= next_idx_nxt;
      en_r       <= en_nxt;
      rdy_r      <= rdy_nxt;
      cop_r      <= cop_nxt;
      poll_r     <= poll_nxt;
      walk_r     <= walk_nxt;
    end
  end

  // Statistics: cleared on reset, one write per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) begin
        cnt_r[i] <= '0;
      end
    end else if (cnt_wr) begin
      cnt_r[cnt_id_r] <= cnt_wdata;
    end
  end

  // Payload of the event and the result beat
  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    status_r   <= status_nxt;
    start_rd_r <= start_rd_nxt;
    addr_r     <= addr_nxt;
    abort_r    <= abort_nxt;
    cnt_id_r   <= cnt_id_nxt;
    try_id_r   <= try_id_nxt;
  end

  assign busy      = (state_r != SQ_IDLE);
  assign out_valid = (state_r == SQ_OUT);

  always_comb begin
    out_data.status           = status_r;
    out_data.start_read       = start_rd_r;
    out_data.target_address   = addr_r;
    out_data.abort_transfer   = abort_r;
    out_data.controller_state = ctrl_r;
    out_data.active_device    = active_r;
    out_data.data_ready       = sid_ok & rdy_r[item_r.slave_id];
    out_data.error_count      = sid_ok ? rd_ent.err  : 16'd0;
    out_data.success_count    = sid_ok ? rd_ent.succ : 16'd0;
  end

  // A result beat lasts one cycle and frees the block
  a_beat_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid && !busy)
    else $error("result beat longer than one cycle");

  // An accepted event makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted event did not raise busy");

  // The active device is a device index or none
  a_active_range: assert property (@(posedge clk) disable iff (!rst_n)
    active_r <= pdrs_pkg::NONE_ID)
    else $error("active device out of range");

  // A started read leaves the controller waiting or in error
  a_start_state: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && start_rd_r) |->
      (ctrl_r == pdrs_pkg::CTRL_WAIT || ctrl_r == pdrs_pkg::CTRL_ERROR))
    else $error("read started without waiting or error state");

  // An abort drops the active device and enters error
  a_abort_state: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && abort_r) |->
      (ctrl_r == pdrs_pkg::CTRL_ERROR && active_r == pdrs_pkg::NONE_ID))
    else $error("abort without error state");

endmodule

// ===== hdl/pdrs_alu.sv =====
module pdrs_alu (
  input  pdrs_pkg::alu_req_t req,
  output pdrs_pkg::alu_rsp_t rsp
);

  logic [16:0] diff;
  logic [15:0] sat;

  assign diff = {1'b0, req.a} - {1'b0, req.b};
  assign sat  = req.narrow ? pdrs_pkg::SAT_NARROW : pdrs_pkg::SAT_WIDE;

  always_comb begin
    rsp.ge  = ~diff[16];
    rsp.gt  = ~diff[16] && (diff[15:0] != 16'd0);
    rsp.inc = (req.a >= sat) ? sat : req.a + 16'd1;
  end

endmodule

// ===== hdl/pdrs_cfg.sv =====
module pdrs_cfg (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [4:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  output pdrs_pkg::cfg_t       cfg,
  output logic                 seq_wr
);

  pdrs_pkg::cfg_t cfg_r, cfg_nxt;
  logic           wr;
  logic [2:0]     idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[4:2];
  assign seq_wr = wr && (idx == pdrs_pkg::REG_SEQ_MODE);
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr) begin
      unique case (idx)
        pdrs_pkg::REG_DEVICE_COUNT: cfg_nxt.device_count    = pwdata[2:0];
        pdrs_pkg::REG_AUTO_RETRY:   cfg_nxt.auto_retry      = pwdata[0];
        pdrs_pkg::REG_SEQ_MODE:     cfg_nxt.sequential_mode = pwdata[0];
        pdrs_pkg::REG_POLL_INTVL: begin
          // a zero interval falls back to the default
          cfg_nxt.poll_interval = (pwdata[15:0] == 16'd0) ? pdrs_pkg::DEFAULT_INTERVAL
                                                          : pwdata[15:0];
        end
        pdrs_pkg::REG_DEV_ADDR0:    cfg_nxt.dev_addr[0] = pwdata[9:0];
        pdrs_pkg::REG_DEV_ADDR1:    cfg_nxt.dev_addr[1] = pwdata[9:0];
        pdrs_pkg::REG_DEV_ADDR2:    cfg_nxt.dev_addr[2] = pwdata[9:0];
        pdrs_pkg::REG_DEV_ADDR3:    cfg_nxt.dev_addr[3] = pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      pdrs_pkg::REG_DEVICE_COUNT: prdata = {29'd0, cfg_r.device_count};
      pdrs_pkg::REG_AUTO_RETRY:   prdata = {31'd0, cfg_r.auto_retry};
      pdrs_pkg::REG_SEQ_MODE:     prdata = {31'd0, cfg_r.sequential_mode};
      pdrs_pkg::REG_POLL_INTVL:   prdata = {16'd0, cfg_r.poll_interval};
      pdrs_pkg::REG_DEV_ADDR0:    prdata = {22'd0, cfg_r.dev_addr[0]};
      pdrs_pkg::REG_DEV_ADDR1:    prdata = {22'd0, cfg_r.dev_addr[1]};
      pdrs_pkg::REG_DEV_ADDR2:    prdata = {22'd0, cfg_r.dev_addr[2]};
      pdrs_pkg::REG_DEV_ADDR3:    prdata = {22'd0, cfg_r.dev_addr[3]};
      default:                    prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.device_count    <= 3'd0;
      cfg_r.auto_retry      <= 1'b1;
      cfg_r.sequential_mode <= 1'b0;
      cfg_r.poll_interval   <= pdrs_pkg::DEFAULT_INTERVAL;
      cfg_r.dev_addr        <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ===== test/testbench.sv =====
module testbench;

  // Mode code left unused by the block; it must still answer with one report
  localparam logic [2:0] MODE_UNUSED = 3'd7;
  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 16;

  typedef struct {
    pdrs_pkg::in_t ev;
    bit            drain;
  } pending_t;

  logic           clk     = 1'b0;
  logic           rst_n   = 1'b0;
  logic           start   = 1'b0;
  logic           busy;
  pdrs_pkg::in_t  in_data = '0;
  logic           out_valid;
  pdrs_pkg::out_t out_data;
  logic           psel    = 1'b0;
  logic           penable = 1'b0;
  logic           pwrite  = 1'b0;
  logic [4:0]     paddr   = '0;
  logic [31:0]    pwdata  = '0;
  logic [31:0]    prdata;
  logic           pready;

  polled_device_read_scheduler_core dut (
    .clk, .rst_n, .start, .busy, .in_data, .out_valid, .out_data,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #4 clk = ~clk;

  // Shadow of the register file
  logic [2:0]  cfg_dev_count;
  logic        cfg_auto_retry;
  logic        cfg_seq_mode;
  logic [15:0] cfg_poll_intvl;
  logic [9:0]  cfg_dev_addr [4];

  // Scheduler state as the block should hold it
  logic [1:0]  ctl_state;
  logic [2:0]  act_id;
  logic [15:0] st_tmr;
  logic [15:0] pl_tmr;
  int          nxt_idx;
  logic        dev_enabled [4];
  logic        dev_ready [4];
  logic [15:0] err_cnt [4];
  logic [15:0] succ_cnt [4];
  logic [3:0]  retry_cnt [4];
  logic        rd_start;
  logic [9:0]  rd_addr;

  pending_t       event_q[$];
  pdrs_pkg::out_t report_q[$];
  pending_t       head_item;
  pdrs_pkg::out_t report_want;
  int             n_events_taken = 0;
  int             n_reports_seen = 0;
  int             n_errors = 0;
  int             gap_left = 0;
  int             stall_cycles = 0;
  bit             idle_on = 1'b1;

  function automatic int eff_count();
    return (cfg_dev_count > pdrs_pkg::MAX_DEVICES) ? int'(pdrs_pkg::MAX_DEVICES)
                                                  : int'(cfg_dev_count);
  endfunction

  function automatic logic [15:0] sat16(logic [15:0] v);
    return (v == pdrs_pkg::SAT_WIDE) ? v : v + 16'd1;
  endfunction

  function automatic logic [3:0] sat4(logic [3:0] v);
    return (v == 4'hF) ? v : v + 4'd1;
  endfunction

  function automatic bit active_valid();
    return act_id < eff_count();
  endfunction

  function automatic void go_state(logic [1:0] s);
    ctl_state = s;
    st_tmr = '0;
  endfunction

  function automatic logic [1:0] attempt_read(int id, logic br, logic ok);
    if (id >= eff_count() || !dev_enabled[id]) return pdrs_pkg::RES_ERR;
    if (ctl_state != pdrs_pkg::CTRL_IDLE || !br) return pdrs_pkg::RES_BUSY;
    act_id = 3'(id);
    rd_start = 1'b1;
    rd_addr = cfg_dev_addr[id];
    if (ok) begin
      go_state(pdrs_pkg::CTRL_WAIT);
      return pdrs_pkg::RES_OK;
    end
    go_state(pdrs_pkg::CTRL_ERROR);
    err_cnt[id] = sat16(err_cnt[id]);
    return pdrs_pkg::RES_ERR;
  endfunction

  // Advance the scheduler by one event and return the report it should strobe
  function automatic pdrs_pkg::out_t schedule_event(pdrs_pkg::in_t ev);
    pdrs_pkg::out_t r;
    int             sid;
    int             id;
    int             a;
    int             looked;
    bit             hit;
    bit             sid_ok;
    logic [1:0]     stat;
    logic           abrt;
    sid = ev.slave_id;
    sid_ok = sid < eff_count();
    stat = pdrs_pkg::RES_OK;
    abrt = 1'b0;
    rd_start = 1'b0;
    rd_addr = '0;
    case (ev.mode)
      pdrs_pkg::MODE_TICK: begin
        st_tmr = sat16(st_tmr);
        pl_tmr = sat16(pl_tmr);
        case (ctl_state)
          pdrs_pkg::CTRL_IDLE: begin
            if (cfg_seq_mode && pl_tmr >= cfg_poll_intvl) begin
              // walk the ring from the poll pointer to the first enabled entry
              stat = pdrs_pkg::RES_ERR;
              looked = 0;
              hit = 1'b0;
              while (!hit && looked < eff_count()) begin
                id = nxt_idx & 3;
                nxt_idx = (nxt_idx + 1) % eff_count();
                looked++;
                if (dev_enabled[id]) begin
                  hit = 1'b1;
                  stat = attempt_read(id, ev.bus_ready, ev.start_ok);
                end
              end
              if (stat == pdrs_pkg::RES_OK) pl_tmr = '0;
            end
          end
          pdrs_pkg::CTRL_WAIT: begin
            if (st_tmr > pdrs_pkg::TIMEOUT_TICKS) begin
              if (active_valid()) begin
                err_cnt[act_id] = sat16(err_cnt[act_id]);
                retry_cnt[act_id] = sat4(retry_cnt[act_id]);
                abrt = 1'b1;
              end
              go_state(pdrs_pkg::CTRL_ERROR);
              act_id = pdrs_pkg::NONE_ID;
            end
          end
          pdrs_pkg::CTRL_RETRY: begin
            if (!active_valid()) begin
              ctl_state = pdrs_pkg::CTRL_IDLE;
            end else if (st_tmr > pdrs_pkg::RETRY_DELAY) begin
              // restart ignores bus_ready
              rd_start = 1'b1;
              rd_addr = cfg_dev_addr[act_id];
              if (ev.start_ok) begin
                go_state(pdrs_pkg::CTRL_WAIT);
              end else begin
                go_state(pdrs_pkg::CTRL_ERROR);
                act_id = pdrs_pkg::NONE_ID;
              end
            end
          end
          default: begin
            if (st_tmr > pdrs_pkg::ERROR_HOLD) ctl_state = pdrs_pkg::CTRL_IDLE;
          end
        endcase
      end
      pdrs_pkg::MODE_READ: stat = attempt_read(sid, ev.bus_ready, ev.start_ok);
      pdrs_pkg::MODE_DONE: begin
        if (active_valid() && dev_enabled[act_id]) begin
          dev_ready[act_id] = 1'b1;
          succ_cnt[act_id] = sat16(succ_cnt[act_id]);
          retry_cnt[act_id] = '0;
        end
        ctl_state = pdrs_pkg::CTRL_IDLE;
        act_id = pdrs_pkg::NONE_ID;
      end
      pdrs_pkg::MODE_ERROR: begin
        if (active_valid()) begin
          a = act_id;
          err_cnt[a] = sat16(err_cnt[a]);
          retry_cnt[a] = sat4(retry_cnt[a]);
          if (cfg_auto_retry && retry_cnt[a] < pdrs_pkg::MAX_RETRIES) begin
            go_state(pdrs_pkg::CTRL_RETRY);
          end else begin
            go_state(pdrs_pkg::CTRL_ERROR);
            retry_cnt[a] = '0;
            act_id = pdrs_pkg::NONE_ID;
          end
        end else begin
          go_state(pdrs_pkg::CTRL_ERROR);
          act_id = pdrs_pkg::NONE_ID;
        end
      end
      pdrs_pkg::MODE_ENABLE: if (sid_ok) dev_enabled[sid] = ev.enable_value;
      pdrs_pkg::MODE_CLEAR: if (sid_ok) dev_ready[sid] = 1'b0;
      pdrs_pkg::MODE_RESET: begin
        if (sid_ok) begin
          err_cnt[sid] = '0;
          succ_cnt[sid] = '0;
          retry_cnt[sid] = '0;
        end
      end
      default: ;
    endcase
    r.status = stat;
    r.start_read = rd_start;
    r.target_address = rd_addr;
    r.abort_transfer = abrt;
    r.controller_state = ctl_state;
    r.active_device = act_id;
    r.data_ready = sid_ok ? dev_ready[sid] : 1'b0;
    r.error_count = sid_ok ? err_cnt[sid] : '0;
    r.success_count = sid_ok ? succ_cnt[sid] : '0;
    return r;
  endfunction

  function automatic void check_field(string fname, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      n_errors++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, fname, want, got);
    end
  endfunction

  function automatic pdrs_pkg::in_t make_event(logic [2:0] mode, int sid, logic en,
                                               logic br, logic ok);
    pdrs_pkg::in_t e;
    e.mode = mode;
    e.slave_id = sid[1:0];
    e.enable_value = en;
    e.bus_ready = br;
    e.start_ok = ok;
    return e;
  endfunction

  function automatic pdrs_pkg::in_t rand_tick();
    return make_event(pdrs_pkg::MODE_TICK, $urandom_range(0, 3), 1'($urandom_range(0, 1)),
                      $urandom_range(0, 9) != 0, $urandom_range(0, 6) != 0);
  endfunction

  task automatic add_event(pdrs_pkg::in_t ev, bit drain = 1'b0);
    pending_t p;
    p.ev = ev;
    p.drain = drain;
    event_q.push_back(p);
  endtask

  // Random noise events, read transfers with tick runs before each completion, and long tick runs
  task automatic add_random(int count);
    int         made;
    int         pick;
    int         rounds;
    int         k;
    logic [2:0] mode;
    // hold off the first beat until the previous phase has fully drained
    add_event(rand_tick(), 1'b1);
    made = 1;
    while (made < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        pick = $urandom_range(0, 99);
        mode = (pick < 40) ? pdrs_pkg::MODE_TICK   : (pick < 55) ? pdrs_pkg::MODE_READ  :
               (pick < 65) ? pdrs_pkg::MODE_DONE   : (pick < 75) ? pdrs_pkg::MODE_ERROR :
               (pick < 83) ? pdrs_pkg::MODE_ENABLE : (pick < 90) ? pdrs_pkg::MODE_CLEAR :
               (pick < 96) ? pdrs_pkg::MODE_RESET  : MODE_UNUSED;
        add_event(make_event(mode, $urandom_range(0, 3), $urandom_range(0, 9) < 7,
                             $urandom_range(0, 9) != 0, $urandom_range(0, 6) != 0),
                  $urandom_range(0, 99) == 0);
        made++;
      end else if (pick < 85) begin
        add_event(make_event(pdrs_pkg::MODE_READ, $urandom_range(0, 3), 1'b1,
                             $urandom_range(0, 9) != 0, $urandom_range(0, 6) != 0));
        made++;
        rounds = $urandom_range(1, 3);
        repeat (rounds) begin
          // now and then sit long enough in waiting to hit the timeout
          k = ($urandom_range(0, 9) == 0) ? $urandom_range(101, 104) : $urandom_range(0, 14);
          repeat (k) add_event(rand_tick());
          add_event(make_event(($urandom_range(0, 9) < 6) ? pdrs_pkg::MODE_DONE
                                                          : pdrs_pkg::MODE_ERROR,
                               $urandom_range(0, 3), 1'($urandom_range(0, 1)),
                               1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
          made += k + 1;
        end
      end else begin
        k = (pick < 96) ? $urandom_range(11, 60) : $urandom_range(101, 110);
        repeat (k) add_event(rand_tick());
        made += k;
      end
    end
  endtask

  // Wait until every queued beat is taken and every report has come back
  task automatic settle();
    @(negedge clk);
    while (event_q.size() != 0 || start || n_events_taken != n_reports_seen) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      pdrs_pkg::REG_DEVICE_COUNT: cfg_dev_count = val[2:0];
      pdrs_pkg::REG_AUTO_RETRY:   cfg_auto_retry = val[0];
      pdrs_pkg::REG_SEQ_MODE: begin
        cfg_seq_mode = val[0];
        pl_tmr = '0;
        nxt_idx = 0;
      end
      pdrs_pkg::REG_POLL_INTVL: begin
        cfg_poll_intvl = (val[15:0] == 16'd0) ? pdrs_pkg::DEFAULT_INTERVAL : val[15:0];
      end
      // address registers: low index bits pick the device
      default: cfg_dev_addr[idx[1:0]] = val[9:0];
    endcase
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
  endtask

  // Driver: take a beat when start meets !busy, then load the next one or idle
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        report_q.push_back(schedule_event(in_data));
        n_events_taken <= n_events_taken + 1;
      end
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (event_q.size() == 0) begin
          start <= 1'b0;
        end else if (event_q[0].drain &&
                     (start || n_events_taken != n_reports_seen + out_valid)) begin
          start <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
          gap_left = $urandom_range(0, 8);
          start <= 1'b0;
        end else begin
          head_item = event_q.pop_front();
          in_data <= head_item.ev;
          start <= 1'b1;
        end
      end
    end
  end

  // Monitor: every strobe retires the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      n_reports_seen <= n_reports_seen + 1;
      if (report_q.size() == 0) begin
        n_errors++;
        $display("%0t: report with nothing expected: expected none, actual %h",
                 $time, out_data);
      end else begin
        report_want = report_q.pop_front();
        check_field("status", report_want.status, out_data.status);
        check_field("start_read", report_want.start_read, out_data.start_read);
        check_field("target_address", report_want.target_address, out_data.target_address);
        check_field("abort_transfer", report_want.abort_transfer, out_data.abort_transfer);
        check_field("controller_state", report_want.controller_state,
                    out_data.controller_state);
        check_field("active_device", report_want.active_device, out_data.active_device);
        check_field("data_ready", report_want.data_ready, out_data.data_ready);
        check_field("error_count", report_want.error_count, out_data.error_count);
        check_field("success_count", report_want.success_count, out_data.success_count);
      end
    end
  end

  // Watchdog: give up after a long stretch with no beat moving anywhere
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (psel && penable && pwrite)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("** polled_device_read_scheduler_core: FAILED **");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    cfg_dev_count = '0;
    cfg_auto_retry = 1'b1;
    cfg_seq_mode = 1'b0;
    cfg_poll_intvl = pdrs_pkg::DEFAULT_INTERVAL;
    ctl_state = pdrs_pkg::CTRL_IDLE;
    act_id = pdrs_pkg::NONE_ID;
    st_tmr = '0;
    pl_tmr = '0;
    nxt_idx = 0;
    for (int i = 0; i < 4; i++) begin
      cfg_dev_addr[i] = '0;
      dev_enabled[i] = 1'b1;
      dev_ready[i] = 1'b0;
      err_cnt[i] = '0;
      succ_cnt[i] = '0;
      retry_cnt[i] = '0;
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // No devices registered yet: reads refuse, done only moves the state
    add_event(make_event(pdrs_pkg::MODE_READ, 0, 1'b1, 1'b1, 1'b1));
    add_event(make_event(pdrs_pkg::MODE_DONE, 2, 1'b0, 1'b1, 1'b1));
    add_event(make_event(MODE_UNUSED, 3, 1'b1, 1'b0, 1'b0));
    settle();

    cfg_write(pdrs_pkg::REG_DEVICE_COUNT, 32'd4);
    cfg_write(pdrs_pkg::REG_AUTO_RETRY, 32'd1);
    cfg_write(pdrs_pkg::REG_SEQ_MODE, 32'd0);
    cfg_write(pdrs_pkg::REG_POLL_INTVL, 32'd0);
    cfg_write(pdrs_pkg::REG_DEV_ADDR0, 32'd0);
    cfg_write(pdrs_pkg::REG_DEV_ADDR1, 32'd1023);
    cfg_write(pdrs_pkg::REG_DEV_ADDR2, 32'h155);
    cfg_write(pdrs_pkg::REG_DEV_ADDR3, 32'h2AA);
    add_event(make_event(pdrs_pkg::MODE_READ, 1, 1'b1, 1'b1, 1'b1));
    add_event(make_event(pdrs_pkg::MODE_READ, 2, 1'b1, 1'b1, 1'b1));
    add_event(make_event(pdrs_pkg::MODE_DONE, 0, 1'b0, 1'b0, 1'b0));
    add_event(make_event(pdrs_pkg::MODE_CLEAR, 1, 1'b0, 1'b1, 1'b1));
    add_event(make_event(pdrs_pkg::MODE_READ, 3, 1'b1, 1'b0, 1'b1));
    add_event(make_event(pdrs_pkg::MODE_READ, 3, 1'b1, 1'b1, 1'b0));
    add_event(make_event(pdrs_pkg::MODE_DONE, 3, 1'b1, 1'b1, 1'b1));
    add_event(make_event(pdrs_pkg::MODE_ENABLE, 0, 1'b0, 1'b1, 1'b1));
    add_event(make_event(pdrs_pkg::MODE_READ, 0, 1'b0, 1'b1, 1'b1));
    add_event(make_event(pdrs_pkg::MODE_ENABLE, 0, 1'b1, 1'b1, 1'b1));
    add_event(make_event(pdrs_pkg::MODE_READ, 0, 1'b1, 1'b1, 1'b1));
    add_event(make_event(pdrs_pkg::MODE_ERROR, 0, 1'b0, 1'b1, 1'b1));
    add_event(make_event(pdrs_pkg::MODE_RESET, 3, 1'b0, 1'b1, 1'b1));
    // sit out the retry delay; the restart must not look at bus_ready
    repeat (11) add_event(make_event(pdrs_pkg::MODE_TICK, 2, 1'b0, 1'b0, 1'b1));
    add_random(130);
    settle();

    cfg_write(pdrs_pkg::REG_DEVICE_COUNT, 32'd3);
    cfg_write(pdrs_pkg::REG_AUTO_RETRY, 32'd0);
    cfg_write(pdrs_pkg::REG_POLL_INTVL, 32'd1);
    cfg_write(pdrs_pkg::REG_SEQ_MODE, 32'd1);
    cfg_write(pdrs_pkg::REG_DEV_ADDR0, $urandom_range(0, 1023));
    add_random(150);
    settle();

    cfg_write(pdrs_pkg::REG_DEVICE_COUNT, 32'd7);
    cfg_write(pdrs_pkg::REG_AUTO_RETRY, 32'd1);
    cfg_write(pdrs_pkg::REG_POLL_INTVL, 32'd5);
    cfg_write(pdrs_pkg::REG_SEQ_MODE, 32'd1);
    cfg_write(pdrs_pkg::REG_DEV_ADDR0, $urandom_range(0, 1023));
    cfg_write(pdrs_pkg::REG_DEV_ADDR1, $urandom_range(0, 1023));
    cfg_write(pdrs_pkg::REG_DEV_ADDR2, $urandom_range(0, 1023));
    cfg_write(pdrs_pkg::REG_DEV_ADDR3, $urandom_range(0, 1023));
    add_random(150);
    settle();

    // Shrink the ring without touching sequential mode: the poll pointer keeps its old
    // value and may point past the last device
    cfg_write(pdrs_pkg::REG_DEVICE_COUNT, 32'd1);
    cfg_write(pdrs_pkg::REG_POLL_INTVL, 32'd2);
    add_random(120);
    settle();

    cfg_write(pdrs_pkg::REG_DEVICE_COUNT, 32'd2);
    cfg_write(pdrs_pkg::REG_SEQ_MODE, 32'd0);
    cfg_write(pdrs_pkg::REG_POLL_INTVL, 32'd65535);
    add_random(100);
    settle();

    // Last stretch runs back to back
    cfg_write(pdrs_pkg::REG_DEVICE_COUNT, 32'd4);
    cfg_write(pdrs_pkg::REG_POLL_INTVL, 32'd3);
    cfg_write(pdrs_pkg::REG_SEQ_MODE, 32'd1);
    cfg_write(pdrs_pkg::REG_DEV_ADDR0, 32'd1023);
    cfg_write(pdrs_pkg::REG_DEV_ADDR3, 32'd0);
    idle_on = 1'b0;
    add_random(200);
    settle();

    if (report_q.size() != 0) begin
      n_errors += report_q.size();
      $display("%0t: %0d expected reports never arrived", $time, report_q.size());
    end
    if (n_errors == 0) begin
      $display("** polled_device_read_scheduler_core: PASSED **");
    end else begin
      $display("** polled_device_read_scheduler_core: FAILED **");
    end
    $finish;
  end

endmodule
